### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the median filter
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define SWM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// types and constants shared by the sliding window median cells and top
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

   localparam int SAMPLE_W = 32;
   localparam int CSR_W    = 7;
   localparam logic [CSR_W-1:0] WINDOW_RESET = 7'd3;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // command broadcast to every cell
   typedef struct packed {
      logic       load;
      logic       restart;
      logic       clear;
      logic       full;
      sample_type sample;
   } swm_cmd_type;

   // what a cell shows its neighbours
   typedef struct packed {
      logic       held;
      logic       v;
      logic       live;
      logic       dseen;
      logic       gt;
      sample_type value;
   } swm_link_type;

endpackage

`default_nettype wire

### design/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// one slot of the sorted window: holds a sample and its age, and on each
// beat keeps its entry or takes one from a neighbour or the new sample
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell import swm_pkg::*; #(
   parameter int AGE_W = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire swm_cmd_type      cmd,
   input  wire logic [AGE_W-1:0] km1,
   input  wire swm_link_type     left,
   input  wire logic [AGE_W-1:0] left_age,
   input  wire swm_link_type     right,
   input  wire logic [AGE_W-1:0] right_age,
   output swm_link_type          link,
   output logic [AGE_W-1:0]      age
);

   logic             valid_ff, valid_in;
   sample_type       value_ff, value_in;
   logic [AGE_W-1:0] age_ff, age_in;

   logic v, del, live, dseen, gt;
   logic mv_left, stay, mv_right;

   always_comb begin
      v        = valid_ff && !cmd.restart;
      del      = v && cmd.full && (age_ff == km1);
      live     = v && !del;
      dseen    = left.dseen || del;
      gt       = $signed(cmd.sample) < $signed(value_ff);
      mv_left  = right.live && dseen && !right.gt;
      stay     = live && (left.dseen == gt);
      mv_right = left.live && !left.dseen && left.gt;
      valid_in = cmd.full ? v : (v || left.v);

      if (mv_left) begin
         value_in = right.value;
         age_in   = right_age + 1'b1;
      end else if (stay) begin
         value_in = value_ff;
         age_in   = age_ff + 1'b1;
      end else if (mv_right) begin
         value_in = left.value;
         age_in   = left_age + 1'b1;
      end else begin
         value_in = cmd.sample;
         age_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.clear) begin
         valid_ff <= 1'b0;
      end else if (cmd.load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   always_comb begin
      link.held  = valid_ff;
      link.v     = v;
      link.live  = live;
      link.dseen = dseen;
      link.gt    = gt;
      link.value = value_ff;
      age        = age_ff;
   end

endmodule

`default_nettype wire

### design/sliding_window_median_top.sv
// ----------------------------------------------------------------------------
// sliding_window_median_top
// running lower median over the last window_size signed samples
// ----------------------------------------------------------------------------
// Samples enter on the req_ channel (req_sample, req_restart) and medians
// leave on the rsp_ channel (rsp_median); a beat moves when valid is high
// and stall is low. The window is a row of WINDOW_MAX cells kept in sorted
// order; on each sample the cell with the oldest entry drops it if the
// window is full and the cells shift by one place towards the insertion
// point, so one sample is taken per cycle while req_stall is low.
// Once the window holds window_size samples every sample yields one median,
// first held as pending, then registered on rsp_. Samples before that
// give no beat. req_restart empties the window before its sample is taken.
// Writing csr_window_size (csr_write_en) empties the window; 0 acts as 1
// and values above WINDOW_MAX act as WINDOW_MAX. Write it only when idle.
// A stalled rsp_ holds its beat; one further median may wait inside, after
// which req_stall rises until the receiver takes the held beat.
// Reset empties the window, drops any pending result and sets the window
// size to 3.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sliding_window_median_top import swm_pkg::*; #(
   parameter int WINDOW_MAX = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [31:0]      req_sample,
   input  wire logic             req_restart,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [31:0]           rsp_median,
   input  wire logic             csr_write_en,
   input  wire logic [CSR_W-1:0] csr_window_size
);

   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   logic [CSR_W-1:0] window_ff;
   logic [CW-1:0]    fill_ff, fill_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sample_type       rsp_median_ff;

   logic [CW-1:0]    win_k, mid, fill_eff, fill_next;
   logic [CW:0]      mid_sum;
   logic [AW-1:0]    km1;
   logic             accept, full, emit, rsp_load;
   sample_type       med_sel;
   swm_cmd_type      cmd;

   swm_link_type     links [WINDOW_MAX];
   logic [AW-1:0]    ages  [WINDOW_MAX];
   logic [WINDOW_MAX-1:0] held_vec;

   always_comb begin
      if (window_ff == '0) begin
         win_k = CW'(1);
      end else if (int'(window_ff) > WINDOW_MAX) begin
         win_k = CW'(WINDOW_MAX);
      end else begin
         win_k = CW'(window_ff);
      end
   end

   always_comb begin
      km1       = AW'(win_k - 1'b1);
      mid_sum   = {1'b0, win_k} + 1'b1;
      mid       = CW'((mid_sum >> 1) - 1'b1);
      accept    = req_valid && !req_stall;
      fill_eff  = req_restart ? '0 : fill_ff;
      full      = fill_eff >= win_k;
      fill_next = full ? fill_eff : fill_eff + 1'b1;
      emit      = fill_next == win_k;
      rsp_load  = pend_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall = pend_ff && !rsp_load;

      fill_in      = accept ? fill_next : fill_ff;
      pend_in      = accept ? emit : (rsp_load ? 1'b0 : pend_ff);
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

      cmd.load    = accept;
      cmd.restart = req_restart;
      cmd.clear   = csr_write_en;
      cmd.full    = full;
      cmd.sample  = req_sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            window_ff <= csr_window_size;
            fill_ff   <= '0;
            pend_ff   <= 1'b0;
         end else begin
            fill_ff <= fill_in;
            pend_ff <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_median_ff <= med_sel;
      end
   end

   // lower median is the cell at the mid rank
   always_comb begin
      med_sel = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         med_sel = med_sel | (links[i].value & {SAMPLE_W{CW'(i) == mid}});
      end
   end

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swm_link_type  left_l, right_l;
      logic [AW-1:0] left_a, right_a;

      if (i == 0) begin : g_first
         always_comb begin
            left_l       = '0;
            left_l.v     = 1'b1;
            left_a       = '0;
         end
      end else begin : g_mid_left
         always_comb begin
            left_l = links[i-1];
            left_a = ages[i-1];
         end
      end

      if (i == WINDOW_MAX - 1) begin : g_last
         always_comb begin
            right_l = '0;
            right_a = '0;
         end
      end else begin : g_mid_right
         always_comb begin
            right_l = links[i+1];
            right_a = ages[i+1];
         end
      end

      swm_cell #(
         .AGE_W(AW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .km1       (km1),
         .left      (left_l),
         .left_age  (left_a),
         .right     (right_l),
         .right_age (right_a),
         .link      (links[i]),
         .age       (ages[i])
      );

      assign held_vec[i] = links[i].held;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

   `SWM_ASSERT(a_fill_matches_cells, clock, reset, $countones(held_vec) == int'(fill_ff), "cell valid bits disagree with fill count")
   `SWM_ASSERT(a_fill_in_window, clock, reset, fill_ff <= win_k, "fill count beyond window")
   `SWM_ASSERT_NEXT(a_full_gives_median, clock, reset, accept && emit && !csr_write_en, pend_ff, "full window gave no median")

endmodule

`default_nettype wire

### sim/sliding_window_median_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_median_top_tb
// self-checking bench for the running lower median filter
// ----------------------------------------------------------------------------
// Drives samples on the req_ channel under random sender gaps and receiver
// stalls, and keeps its own sorted copy of the window to work out each
// lower median. Every rsp_ beat is checked against the oldest expected median.
// The window size is swept across the clamped extremes between phases, with
// restarts, a long receiver hold-off that backs the block up, and sender
// pauses that drain it.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median_top_tb;
   import swm_pkg::*;

   localparam int WINDOW_MAX    = 64;
   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_CYCLES   = 60;
   localparam int SETTLE_CYCLES = 4;
   localparam sample_type SAMPLE_MIN = sample_type'(32'h8000_0000);
   localparam sample_type SAMPLE_MAX = sample_type'(32'h7fff_ffff);

   class median_scoreboard;
      sample_type  window_fifo[$];
      sample_type  window_sorted[$];
      sample_type  expected_medians[$];
      int unsigned span;
      int          errors;
      int          samples_taken;
      int          medians_matched;

      function new();
         set_window(WINDOW_RESET);
      endfunction

      function void set_window(logic [CSR_W-1:0] raw);
         if (raw == 0) begin
            span = 1;
         end else if (raw > WINDOW_MAX) begin
            span = WINDOW_MAX;
         end else begin
            span = raw;
         end
         window_fifo.delete();
         window_sorted.delete();
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task note_sample(sample_type s, bit restart);
         sample_type oldest;
         int         pos;
         bit         gone;
         if (restart) begin
            window_fifo.delete();
            window_sorted.delete();
         end
         while (window_fifo.size() >= span) begin
            oldest = window_fifo.pop_front();
            gone = 1'b0;
            for (int i = 0; i < window_sorted.size() && !gone; i++) begin
               if (window_sorted[i] == oldest) begin
                  window_sorted.delete(i);
                  gone = 1'b1;
               end
            end
         end
         window_fifo.insert(window_fifo.size(), s);
         pos = 0;
         while (pos < window_sorted.size() && window_sorted[pos] <= s) pos++;
         window_sorted.insert(pos, s);
         samples_taken++;
         if (window_sorted.size() == span) begin
            expected_medians.insert(expected_medians.size(),
                                    window_sorted[(span + 1) / 2 - 1]);
         end
      endtask

      task check_median(sample_type got);
         sample_type want;
         if (expected_medians.size() == 0) begin
            report($sformatf("median %0d with nothing expected", got));
         end else begin
            want = expected_medians.pop_front();
            if (got !== want) begin
               report($sformatf("median %0d, expected %0d", got, want));
            end else begin
               medians_matched++;
            end
         end
      endtask
   endclass

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic [31:0]          req_sample      = '0;
   logic                 req_restart     = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [31:0]          rsp_median;
   logic                 csr_write_en    = 1'b0;
   logic [CSR_W-1:0]     csr_window_size = WINDOW_RESET;

   median_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_req      = 0;
   int hold_left     = 0;
   int idle_cycles   = 0;
   int settings_seen = 1;

   sample_type dir_samples[14] = '{SAMPLE_MAX, SAMPLE_MIN, 0, SAMPLE_MIN, SAMPLE_MIN,
      SAMPLE_MAX, -1, 1, 7, 7, 7, -7, 0, SAMPLE_MAX};
   bit         dir_restart[14] = '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0};
   int         windows[13]     = '{1, 2, 3, 5, 9, 64, 127, 0, 65, 16, 4, 33, 7};

   sliding_window_median_top #(
      .WINDOW_MAX(WINDOW_MAX)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_median     (rsp_median),
      .csr_write_en   (csr_write_en),
      .csr_window_size(csr_window_size)
   );

   always #2 clock = ~clock;

   // receiver: random stalls, or a long hold-off on request
   always @(negedge clock) begin
      if (hold_req != 0) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_median(sample_type'(rsp_median));
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic sample_type random_sample();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: return SAMPLE_MIN;
               1: return SAMPLE_MAX;
               2: return 0;
               default: return -1;
            endcase
         end
         1, 2, 3: return sample_type'(int'($urandom_range(8)) - 4);
         default: return sample_type'($urandom());
      endcase
   endfunction

   task automatic send_sample(input sample_type s, input bit restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_sample  <= s;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_sample(s, restart);
      @(negedge clock);
   endtask

   // stop sending until every expected median has come, then let it settle
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.expected_medians.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_window(input logic [CSR_W-1:0] size);
      csr_write_en    <= 1'b1;
      csr_window_size <= size;
      @(negedge clock);
      csr_write_en <= 1'b0;
      sb.set_window(size);
      settings_seen++;
   endtask

   initial begin
      int count;
      int mode;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // extremes, equal samples and restarts at the reset window size
      for (int i = 0; i < 14; i++) send_sample(dir_samples[i], dir_restart[i]);
      drain();
      // zero behaves as a window of one
      write_window('0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(5, 1'b1);

      for (int p = 0; p < 13; p++) begin
         mode = p * 3 / 13;
         send_idle_pct = (mode == 0) ? 11 : (mode == 1) ? 51 : 0;
         recv_idle_pct = (mode == 0) ? 51 : (mode == 1) ? 11 : 0;
         drain();
         write_window(windows[p][CSR_W-1:0]);
         count = (sb.span >= 32) ? 3 * sb.span : 60;
         for (int n = 0; n < count; n++) begin
            if (n == count / 2) begin
               if (p % 4 == 1) begin
                  hold_req = 1;
               end else if (p % 4 == 3) begin
                  drain();
               end
            end
            send_sample(random_sample(), $urandom_range(4 * sb.span + 7) == 0);
         end
      end

      drain();
      $display("covered %0d samples and %0d medians over %0d window sizes",
               sb.samples_taken, sb.medians_matched, settings_seen);
      $display("sizes 0 to 127 incl. clamping, restarts, receiver hold-off, sender pauses");
      if (sb.errors == 0 && sb.expected_medians.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire
